// File: src/kcmt_pkg.sv
package kcmt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int LABEL_BYTES = 8;

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int ENT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int LABEL_W    = 64;
    localparam int COUNT_W    = 16;
    localparam int BONUS_W    = 8;
    localparam int SLOT_W     = 6;
    localparam int ENTRIES_W  = 7;
    localparam int SUM_W      = COUNT_W + 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LABEL_W-1:0] LABEL_MASK = {LABEL_W{1'b1}} >> (LABEL_W - 8 * LABEL_BYTES);
    localparam logic [ENT_W-1:0]   DEPTH_COUNT = ENT_W'(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic               REG_MERGE_BONUS   = 1'b0;
    localparam logic [BONUS_W-1:0] MERGE_BONUS_RESET = 8'd1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MERGE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [LABEL_W-1:0] type_label;
        logic [COUNT_W-1:0] type_count;
        logic               last_in_fragment;
    } item_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count_now;
        logic [ENTRIES_W-1:0] entries;
        logic                 table_full;
        logic                 last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_APPEND,
        ST_CLEAR,
        ST_VOID,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic hit_write;
        logic append;
        logic clear;
        logic void_op;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic scan_more;
        logic match;
        logic out_room;
    } ctrl_stat_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

    function automatic logic [ENTRIES_W-1:0] to_entries(input logic [ENT_W-1:0] n);
        logic [31:0] wide;
        wide = 32'(n);
        return wide[ENTRIES_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b,
                                                  input logic [BONUS_W-1:0] c);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        return (s > SUM_W'(COUNT_MAX)) ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

// File: src/kcmt_regs.sv
module kcmt_regs
    import kcmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [BONUS_W-1:0]    merge_bonus
);

    logic [BONUS_W-1:0] merge_bonus_reg;
    logic [BONUS_W-1:0] merge_bonus_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        merge_bonus_next = merge_bonus_reg;
        unique case (paddr[2])
            REG_MERGE_BONUS:
            begin
                if (wr_en)
                begin
                    merge_bonus_next = pwdata[BONUS_W-1:0];
                end
            end
            default:
            begin
                merge_bonus_next = merge_bonus_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MERGE_BONUS: prdata = CFG_DATA_W'(merge_bonus_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_bonus_reg <= MERGE_BONUS_RESET;
        end
        else
        begin
            merge_bonus_reg <= merge_bonus_next;
        end
    end

    assign merge_bonus = merge_bonus_reg;

endmodule

// File: src/kcmt_ctrl.sv
module kcmt_ctrl
    import kcmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd,
    output logic       in_stall
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (stat.in_op)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_LOAD:  state_next = ST_APPEND;
                        OP_MERGE: state_next = ST_SCAN;
                        OP_NONE:  state_next = ST_VOID;
                        default:  state_next = ST_VOID;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = ST_HIT;
                end
                else if (!stat.scan_more)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_HIT, ST_APPEND, ST_CLEAR, ST_VOID:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_SCAN:   cmd.scan      = 1'b1;
            ST_HIT:    cmd.hit_write = 1'b1;
            ST_APPEND: cmd.append    = 1'b1;
            ST_CLEAR:  cmd.clear     = 1'b1;
            ST_VOID:   cmd.void_op   = 1'b1;
            ST_DONE:   cmd.load_out  = stat.out_room;
            default:   cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/kcmt_dp.sv
module kcmt_dp
    import kcmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              in_item,
    input  logic [BONUS_W-1:0] merge_bonus,
    input  ctrl_cmd_t          cmd,
    output ctrl_stat_t         stat,
    input  logic               out_stall,
    output logic               out_valid,
    output result_t            out_result
);

    logic [LABEL_W-1:0] label_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_mem [TABLE_DEPTH];

    item_t              item_reg,        item_next;
    logic [ENT_W-1:0]   scan_idx_reg,    scan_idx_next;
    logic               cmp_valid_reg,   cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg,     cmp_idx_next;
    logic [IDX_W-1:0]   hit_idx_reg,     hit_idx_next;
    logic [COUNT_W-1:0] hit_sum_reg,     hit_sum_next;
    logic [ENT_W-1:0]   entry_total_reg, entry_total_next;
    result_t            res_reg,         res_next;
    result_t            out_reg,         out_next;
    logic               out_valid_reg,   out_valid_next;

    logic [LABEL_W-1:0] label_rd_reg;
    logic [COUNT_W-1:0] count_rd_reg;

    logic               scan_more;
    logic               match;
    logic               table_full;
    logic               rd_en;
    logic               label_we;
    logic               count_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] count_wdata;

    assign scan_more  = scan_idx_reg < entry_total_reg;
    assign match      = cmp_valid_reg && (label_rd_reg == item_reg.type_label);
    assign table_full = entry_total_reg == DEPTH_COUNT;
    assign rd_en      = cmd.scan && scan_more;

    assign label_we    = cmd.append && !table_full;
    assign count_we    = label_we || cmd.hit_write;
    assign wr_addr     = cmd.hit_write ? hit_idx_reg : entry_total_reg[IDX_W-1:0];
    assign count_wdata = cmd.hit_write ? hit_sum_reg : item_reg.type_count;

    assign stat.in_op     = in_item.op;
    assign stat.scan_more = scan_more;
    assign stat.match     = match;
    assign stat.out_room  = !out_valid_reg || !out_stall;

    always_comb
    begin
        item_next = item_reg;
        if (cmd.accept)
        begin
            item_next            = in_item;
            item_next.type_label = in_item.type_label & LABEL_MASK;
        end
    end

    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        if (cmd.accept)
        begin
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_valid_next = scan_more;
            cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
            if (scan_more)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        hit_idx_next = hit_idx_reg;
        hit_sum_next = hit_sum_reg;
        if (cmd.scan && match)
        begin
            hit_idx_next = cmp_idx_reg;
            hit_sum_next = sat_add(count_rd_reg, item_reg.type_count, merge_bonus);
        end
    end

    always_comb
    begin
        entry_total_next = entry_total_reg;
        if (cmd.clear)
        begin
            entry_total_next = '0;
        end
        else if (label_we)
        begin
            entry_total_next = entry_total_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.clear || cmd.void_op)
        begin
            res_next            = '0;
            res_next.entries    = cmd.clear ? '0 : to_entries(entry_total_reg);
            res_next.last       = item_reg.last_in_fragment;
        end
        else if (cmd.hit_write)
        begin
            res_next.hit        = 1'b1;
            res_next.slot       = to_slot(hit_idx_reg);
            res_next.count_now  = hit_sum_reg;
            res_next.entries    = to_entries(entry_total_reg);
            res_next.table_full = 1'b0;
            res_next.last       = item_reg.last_in_fragment;
        end
        else if (cmd.append)
        begin
            res_next      = '0;
            res_next.last = item_reg.last_in_fragment;
            if (table_full)
            begin
                res_next.entries    = to_entries(entry_total_reg);
                res_next.table_full = 1'b1;
            end
            else
            begin
                res_next.slot      = to_slot(entry_total_reg[IDX_W-1:0]);
                res_next.count_now = item_reg.type_count;
                res_next.entries   = to_entries(entry_total_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            entry_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            scan_idx_reg    <= scan_idx_next;
            cmp_valid_reg   <= cmp_valid_next;
            entry_total_reg <= entry_total_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_sum_reg <= hit_sum_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (label_we)
        begin
            label_mem[wr_addr] <= item_reg.type_label;
        end
        if (count_we)
        begin
            count_mem[wr_addr] <= count_wdata;
        end
        if (rd_en)
        begin
            label_rd_reg <= label_mem[scan_idx_reg[IDX_W-1:0]];
            count_rd_reg <= count_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

// File: src/keyed_count_merge_table.sv
// Merge: accept, search the valid entries, then write the hit or append and load the result;
// clear, template load and unused op skip the search. One transaction at a time.
// Throughput is set by the label search, one label memory read per cycle.
// A waiting result does not block acceptance of the next transaction.
// Reset (rst_n, async, active low): table empty, merge_bonus 1, output idle;
// table memories keep undefined contents until written.
module keyed_count_merge_table
    import kcmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  item_t                 in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output result_t               out_result
);

    logic [BONUS_W-1:0] merge_bonus;
    ctrl_cmd_t          cmd;
    ctrl_stat_t         stat;

    kcmt_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .merge_bonus (merge_bonus)
    );

    kcmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    kcmt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_item),
        .merge_bonus (merge_bonus),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_result  (out_result)
    );

endmodule

// File: src/kcmt_checker.sv
module kcmt_checker
    import kcmt_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_stall,
    input logic    out_valid,
    input logic    out_stall,
    input result_t out_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_result))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new transaction taken while one is in progress");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result.table_full |->
            !out_result.hit && out_result.count_now == '0 && out_result.slot == '0
            && out_result.entries == to_entries(DEPTH_COUNT))
        else $error("dropped append reports a slot or count");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result.hit |->
            ENTRIES_W'(out_result.slot) < out_result.entries && !out_result.table_full)
        else $error("hit slot beyond valid entries");

    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_result.entries <= to_entries(DEPTH_COUNT))
        else $error("entry count beyond table depth");

endmodule

bind keyed_count_merge_table kcmt_checker u_kcmt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
);

// File: bench/keyed_count_merge_table_tb.sv
`timescale 1ns / 100ps

module keyed_count_merge_table_tb;
    import kcmt_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 150;
    localparam int PHASES          = 5;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    item_t                 in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    result_t               out_result;

    keyed_count_merge_table u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    // table image kept alongside the block
    logic [LABEL_W-1:0] known_labels [TABLE_DEPTH];
    logic [COUNT_W-1:0] known_counts [TABLE_DEPTH];
    int                 known_entries = 0;
    logic [BONUS_W-1:0] bonus_now = MERGE_BONUS_RESET;

    item_t   items_to_send [$];
    result_t outcomes_due [$];

    logic [LABEL_W-1:0] label_pool [12];

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic hold_req = 1'b0;
    int   gap_max = 14;
    int   stall_max = 14;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;
    int   queued_items = 0;
    int   results_checked = 0;
    int   hits_seen = 0;
    int   full_seen = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic result_t predict_table_update(input item_t it);
        result_t            r;
        logic [LABEL_W-1:0] label;
        logic [SUM_W-1:0]   sum;
        logic               found;
        int                 idx;
        r     = '0;
        label = it.type_label & LABEL_MASK;
        found = 1'b0;
        idx   = 0;
        case (it.op)
            OP_CLEAR: known_entries = 0;
            OP_LOAD, OP_MERGE:
            begin
                if (it.op == OP_MERGE) begin
                    for (int i = 0; i < known_entries; i++) begin
                        if (!found && known_labels[i] == label) begin
                            found = 1'b1;
                            idx   = i;
                        end
                    end
                end
                if (found) begin
                    sum = SUM_W'(known_counts[idx]) + SUM_W'(it.type_count) + SUM_W'(bonus_now);
                    known_counts[idx] = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
                    r.hit       = 1'b1;
                    r.slot      = SLOT_W'(idx);
                    r.count_now = known_counts[idx];
                end else if (known_entries >= TABLE_DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    known_labels[known_entries] = label;
                    known_counts[known_entries] = it.type_count;
                    r.slot      = SLOT_W'(known_entries);
                    r.count_now = it.type_count;
                    known_entries++;
                end
            end
            default: ;
        endcase
        r.entries = ENTRIES_W'(known_entries);
        r.last    = it.last_in_fragment;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // accept transactions on both channels, predict and check
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            in_fire  <= in_valid && !in_stall;
            out_fire <= out_valid && !out_stall;
            if (in_valid && !in_stall)
                outcomes_due.push_back(predict_table_update(in_item));
            if (out_valid && !out_stall) begin
                if (outcomes_due.size() == 0) begin
                    $error("result with no transaction outstanding");
                    fail_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    compare_field("hit", want.hit, out_result.hit);
                    compare_field("slot", want.slot, out_result.slot);
                    compare_field("count_now", want.count_now, out_result.count_now);
                    compare_field("entries", want.entries, out_result.entries);
                    compare_field("table_full", want.table_full, out_result.table_full);
                    compare_field("last", want.last, out_result.last);
                    results_checked++;
                    hits_seen += want.hit;
                    full_seen += want.table_full;
                end
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (items_to_send.size() > 0) begin
                in_item  <= items_to_send.pop_front();
                in_valid <= 1'b1;
                gap_left = $urandom_range(0, gap_max);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_req) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (out_fire)
                stall_left = $urandom_range(0, stall_max);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (psel && penable && pwrite && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("keyed_count_merge_table: mismatch");
                $finish;
            end
        end
    end

    task automatic push_item(input op_t op, input logic [LABEL_W-1:0] label,
                             input logic [COUNT_W-1:0] cnt, input logic last);
        item_t it;
        it.op               = op;
        it.type_label       = label;
        it.type_count       = cnt;
        it.last_in_fragment = last;
        items_to_send.push_back(it);
        queued_items++;
    endtask

    function automatic logic [COUNT_W-1:0] draw_count();
        case ($urandom_range(0, 3))
            0: return COUNT_MAX - COUNT_W'($urandom_range(0, 15));
            1: return COUNT_W'($urandom_range(0, 15));
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    task automatic queue_fragment();
        int n;
        int m;
        case ($urandom_range(0, 15))
            0:
            begin
                n = $urandom_range(3, 8);
                for (int k = 0; k < n; k++)
                    push_item(op_t'($urandom_range(0, 3)), {$urandom, $urandom},
                              COUNT_W'($urandom), 1'($urandom));
            end
            1:
            begin
                // fill the table with random labels, overfilling it when n exceeds TABLE_DEPTH
                push_item(OP_CLEAR, {$urandom, $urandom}, COUNT_W'($urandom), 1'b0);
                n = $urandom_range(62, 70);
                for (int k = 0; k < n; k++)
                    push_item(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_MERGE,
                              {$urandom, $urandom}, draw_count(), k == n - 1);
            end
            default:
            begin
                if ($urandom_range(0, 2) == 0)
                    push_item(OP_CLEAR, {$urandom, $urandom}, COUNT_W'($urandom), 1'b0);
                n = $urandom_range(0, 2);
                for (int k = 0; k < n; k++)
                    push_item(OP_LOAD, label_pool[$urandom_range(0, 11)], draw_count(), 1'b0);
                m = $urandom_range(2, 10);
                for (int k = 0; k < m; k++)
                    push_item(OP_MERGE, label_pool[$urandom_range(0, 11)], draw_count(),
                              k == m - 1);
            end
        endcase
    endtask

    task automatic wait_drained();
        do begin
            @(posedge clk);
            #1;
        end while (items_to_send.size() != 0 || in_valid || outcomes_due.size() != 0);
    endtask

    task automatic write_bonus(input logic [BONUS_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(REG_MERGE_BONUS));
        pwdata  <= CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        bonus_now = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [BONUS_W-1:0] phase_bonus [PHASES];
        int                 phase_start;
        phase_bonus = '{8'd0, 8'd255, BONUS_W'($urandom), 8'd1, BONUS_W'($urandom)};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_item(OP_MERGE, '1, COUNT_MAX, 1'b1);
        push_item(OP_MERGE, '1, COUNT_MAX, 1'b0);
        push_item(OP_LOAD, '1, 16'd7, 1'b0);
        push_item(OP_MERGE, '1, 16'd0, 1'b1);
        push_item(OP_MERGE, '0, 16'd0, 1'b0);
        push_item(OP_MERGE, '0, 16'd0, 1'b1);
        push_item(OP_NONE, {$urandom, $urandom}, COUNT_MAX, 1'b1);
        push_item(OP_LOAD, 64'h0000_0000_0043_4241, 16'd100, 1'b0);
        push_item(OP_MERGE, 64'h0000_0000_0043_4241, 16'd65000, 1'b0);
        push_item(OP_MERGE, 64'h0000_0000_0043_4241, 16'd600, 1'b1);
        push_item(OP_MERGE, 64'h4100_0000_0000_0000, 16'd1, 1'b0);
        push_item(OP_CLEAR, '1, COUNT_MAX, 1'b1);
        push_item(OP_NONE, '0, 16'd0, 1'b0);
        push_item(OP_MERGE, '0, 16'd3, 1'b0);
        push_item(OP_MERGE, '0, 16'd4, 1'b1);
        push_item(OP_CLEAR, '0, 16'd0, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            repeat (4) @(posedge clk);
            write_bonus(phase_bonus[p]);
            for (int j = 0; j < 12; j++)
                label_pool[j] = {$urandom, $urandom} >> (8 * $urandom_range(0, 7));
            case (p)
                1:       begin gap_max = 0;  stall_max = 0;  end
                3:       begin gap_max = 0;  stall_max = 14; end
                4:       begin gap_max = 14; stall_max = 0;  end
                default: begin gap_max = 14; stall_max = 14; end
            endcase
            // hold the result side off while the sender keeps offering
            if (p == 2)
                hold_req = 1'b1;
            phase_start = queued_items;
            while (queued_items - phase_start < PHASE_ITEMS)
                queue_fragment();
            wait_drained();
        end

        repeat (80) @(posedge clk);
        if (outcomes_due.size() != 0) begin
            $error("%0d results never arrived", outcomes_due.size());
            fail_count++;
        end
        $display("Checked %0d results: %0d label hits, %0d appends refused by a full table.",
                 results_checked, hits_seen, full_seen);
        $display("Bonus swept over 0, 1, 255 and random values under idling and back-pressure.");
        if (fail_count == 0)
            $display("keyed_count_merge_table: match");
        else
            $display("keyed_count_merge_table: mismatch");
        $finish;
    end

endmodule
